>>> design/line_rasterizer_clipped_defines.svh
// Assertion macros shared by the checker of the line rasterizer.
`ifndef LINE_RASTERIZER_CLIPPED_DEFINES_SVH
`define LINE_RASTERIZER_CLIPPED_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lrc_pkg.sv
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int COORD_W = 13;
  localparam int ERR_W   = 16;
  localparam int DIM_W   = 11;
  localparam int ADDR_W  = 20;
  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 2;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam logic [DIM_W-1:0]  TARGET_DIM_RESET = 11'd256;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE     = 8'd255;

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    REG_TARGET_WIDTH  = 2'd0,
    REG_TARGET_HEIGHT = 2'd1,
    REG_MASK_MODE     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } colour_t;

  // One generated pixel, before clipping and addressing.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    colour_t                   colour;
  } pixel_t;

endpackage

>>> design/lrc_stepper.sv
`timescale 1ns / 1ps

// Bresenham line state. A start transfer loads the line, each tick transfer
// on an active line produces the next pixel into the stage register.
module lrc_stepper (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_accept,
  input  logic                                 command,
  input  logic signed [lrc_pkg::COORD_W-1:0]   x_start,
  input  logic signed [lrc_pkg::COORD_W-1:0]   y_start,
  input  logic signed [lrc_pkg::COORD_W-1:0]   x_stop,
  input  logic signed [lrc_pkg::COORD_W-1:0]   y_stop,
  input  logic [lrc_pkg::CHAN_W-1:0]           red_in,
  input  logic [lrc_pkg::CHAN_W-1:0]           green_in,
  input  logic [lrc_pkg::CHAN_W-1:0]           blue_in,
  input  logic [lrc_pkg::CHAN_W-1:0]           alpha_in,
  input  logic                                 pix_taken,
  output logic                                 pix_valid,
  output lrc_pkg::pixel_t                      pix
);

  localparam int CW = lrc_pkg::COORD_W;
  localparam int EW = lrc_pkg::ERR_W;

  // Control state.
  logic line_active;
  logic first_pending;

  // Line state, loaded on start.
  logic signed [CW-1:0] cur_x;
  logic signed [CW-1:0] cur_y;
  logic signed [CW-1:0] end_major;
  logic signed [EW-1:0] error_term;
  logic signed [EW-1:0] inc_keep;
  logic signed [EW-1:0] inc_step;
  logic                 x_major;
  logic                 minor_up;
  lrc_pkg::colour_t     line_colour;

  // Start decode.
  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic [CW:0]          dx_mag;
  logic [CW:0]          dy_mag;
  logic [CW-1:0]        abs_dx;
  logic [CW-1:0]        abs_dy;
  logic [EW-1:0]        two_dx;
  logic [EW-1:0]        two_dy;
  logic                 x_major_next;
  logic                 minor_up_next;
  logic                 fwd;
  logic signed [EW-1:0] error_next;
  logic signed [EW-1:0] inc_keep_next;
  logic signed [EW-1:0] inc_step_next;
  logic signed [CW-1:0] end_major_next;

  // Tick step.
  logic                 minor_step;
  logic signed [CW-1:0] minor_delta;
  logic signed [CW-1:0] adv_x;
  logic signed [CW-1:0] adv_y;
  logic signed [EW-1:0] adv_err;
  logic signed [CW-1:0] pix_x_next;
  logic signed [CW-1:0] pix_y_next;
  logic signed [EW-1:0] err_step_next;
  logic                 last_next;
  logic                 is_tick;

  always_comb begin
    dx     = {x_stop[CW-1], x_stop} - {x_start[CW-1], x_start};
    dy     = {y_stop[CW-1], y_stop} - {y_start[CW-1], y_start};
    dx_mag = dx[CW] ? (~dx + 1'b1) : dx;
    dy_mag = dy[CW] ? (~dy + 1'b1) : dy;
    abs_dx = dx_mag[CW-1:0];
    abs_dy = dy_mag[CW-1:0];
    two_dx = {{(EW-CW-1){1'b0}}, abs_dx, 1'b0};
    two_dy = {{(EW-CW-1){1'b0}}, abs_dy, 1'b0};

    minor_up_next = (dx[CW] && dy[CW]) ||
                    (!dx[CW] && (dx != '0) && !dy[CW] && (dy != '0));
    x_major_next  = (abs_dy <= abs_dx);

    if (x_major_next) begin
      fwd            = !dx[CW];
      error_next     = $signed(two_dy - EW'(abs_dx));
      inc_keep_next  = $signed(two_dy);
      inc_step_next  = $signed(two_dy - two_dx);
      end_major_next = fwd ? x_stop : x_start;
    end else begin
      fwd            = !dy[CW];
      error_next     = $signed(two_dx - EW'(abs_dy));
      inc_keep_next  = $signed(two_dx);
      inc_step_next  = $signed(two_dx - two_dy);
      end_major_next = fwd ? y_stop : y_start;
    end
  end

  // One Bresenham step. The minor axis moves unless err < 0 (X-major) or
  // err <= 0 (Y-major).
  always_comb begin
    minor_step  = x_major ? !error_term[EW-1]
                          : (!error_term[EW-1] && (error_term != '0));
    minor_delta = minor_up ? 13'sd1 : -13'sd1;
    adv_err     = error_term + (minor_step ? inc_step : inc_keep);
    if (x_major) begin
      adv_x = cur_x + 13'sd1;
      adv_y = minor_step ? (cur_y + minor_delta) : cur_y;
    end else begin
      adv_x = minor_step ? (cur_x + minor_delta) : cur_x;
      adv_y = cur_y + 13'sd1;
    end

    pix_x_next    = first_pending ? cur_x : adv_x;
    pix_y_next    = first_pending ? cur_y : adv_y;
    err_step_next = first_pending ? error_term : adv_err;
    last_next     = x_major ? (pix_x_next >= end_major) : (pix_y_next >= end_major);
    is_tick       = (command == lrc_pkg::CMD_TICK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active   <= 1'b0;
      first_pending <= 1'b0;
      pix_valid     <= 1'b0;
    end else if (in_accept) begin
      if (!is_tick) begin
        line_active   <= 1'b1;
        first_pending <= 1'b1;
        pix_valid     <= 1'b0;
        x_major       <= x_major_next;
        minor_up      <= minor_up_next;
        error_term    <= error_next;
        inc_keep      <= inc_keep_next;
        inc_step      <= inc_step_next;
        end_major     <= end_major_next;
        cur_x         <= fwd ? x_start : x_stop;
        cur_y         <= fwd ? y_start : y_stop;
        line_colour   <= '{alpha: alpha_in, blue: blue_in, green: green_in, red: red_in};
      end else if (line_active) begin
        first_pending <= 1'b0;
        line_active   <= !last_next;
        cur_x         <= pix_x_next;
        cur_y         <= pix_y_next;
        error_term    <= err_step_next;
        pix_valid     <= 1'b1;
        pix           <= '{x: pix_x_next, y: pix_y_next, last: last_next,
                           colour: line_colour};
      end else begin
        pix_valid <= 1'b0;
      end
    end else if (pix_taken) begin
      pix_valid <= 1'b0;
    end
  end

endmodule

>>> design/lrc_pixel_out.sv
`timescale 1ns / 1ps

// Clipping, mask test and framebuffer address, into the output register.
module lrc_pixel_out #(
  parameter int MAX_DIM = lrc_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  input  lrc_pkg::pixel_t                      pix,
  input  logic [lrc_pkg::DIM_W-1:0]            target_width,
  input  logic [lrc_pkg::DIM_W-1:0]            target_height,
  input  logic                                 mask_mode,
  output logic                                 pix_taken,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 pixel_write,
  output logic signed [lrc_pkg::COORD_W-1:0]   pixel_x,
  output logic signed [lrc_pkg::COORD_W-1:0]   pixel_y,
  output logic [lrc_pkg::ADDR_W-1:0]           pixel_address,
  output logic                                 last_pixel,
  output logic [lrc_pkg::CHAN_W-1:0]           red_out,
  output logic [lrc_pkg::CHAN_W-1:0]           green_out,
  output logic [lrc_pkg::CHAN_W-1:0]           blue_out,
  output logic [lrc_pkg::CHAN_W-1:0]           alpha_out
);

  localparam int CW = lrc_pkg::COORD_W;
  localparam int DW = lrc_pkg::DIM_W;
  localparam int PW = 2 * DW;
  localparam logic [CW-1:0] MaxDimV = CW'(MAX_DIM);

  logic          out_load;
  logic [DW-1:0] clip_w;
  logic [DW-1:0] clip_h;
  logic          in_target;
  logic          write_ok;
  logic [PW-1:0] row_base;
  logic [PW-1:0] addr_full;

  always_comb begin
    // Target sizes above the supported maximum saturate to it.
    clip_w = ({{(CW-DW){1'b0}}, target_width}  > MaxDimV) ? MaxDimV[DW-1:0] : target_width;
    clip_h = ({{(CW-DW){1'b0}}, target_height} > MaxDimV) ? MaxDimV[DW-1:0] : target_height;

    in_target = !pix.x[CW-1] && !pix.y[CW-1] &&
                ({1'b0, pix.x[CW-2:0]} < {{(CW-DW){1'b0}}, clip_w}) &&
                ({1'b0, pix.y[CW-2:0]} < {{(CW-DW){1'b0}}, clip_h});
    write_ok = in_target && (!mask_mode || (pix.colour.alpha == lrc_pkg::ALPHA_OPAQUE));

    // Inside the target both coordinates fit the dimension width.
    row_base  = PW'(pix.y[DW-1:0]) * PW'(clip_w);
    addr_full = row_base + PW'(pix.x[DW-1:0]);

    out_load  = !out_valid || !out_stall;
    pix_taken = pix_valid && out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid     <= pix_valid;
      pixel_write   <= write_ok;
      pixel_x       <= pix.x;
      pixel_y       <= pix.y;
      pixel_address <= write_ok ? addr_full[lrc_pkg::ADDR_W-1:0] : '0;
      last_pixel    <= pix.last;
      red_out       <= pix.colour.red;
      green_out     <= pix.colour.green;
      blue_out      <= pix.colour.blue;
      alpha_out     <= pix.colour.alpha;
    end
  end

endmodule

>>> design/line_rasterizer_clipped.sv
`timescale 1ns / 1ps

// Clipped Bresenham line rasterizer.
// Input channel (in_valid / in_stall): command 0 starts a line from the two
// endpoints and the colour; command 1 is a tick that asks for the next pixel.
// A start and a tick on an idle block produce no output transfer. Each tick
// on an active line produces exactly one pixel on the output channel
// (out_valid / out_stall), the last one flagged by last_pixel.
// A tick's pixel is registered first in the step register and then in the
// output register. Throughput is one item per clock while the receiver does
// not stall; each pixel costs one add and compare in the stepper and one 11x11
// multiply for the address in the output stage.
// Pixels outside the target come out with pixel_write low and address zero.
// Configuration: write_enable, register_index and write_data set the target
// width, target height and mask mode; write them only while the block is idle.
// Reset (rst, synchronous) empties both stages, drops any line in progress
// and sets the target to 256 x 256 with mask mode off.
// When the receiver stalls, the output register holds its pixel; the step
// register still fills, and in_stall rises once both stages hold a pixel.
module line_rasterizer_clipped #(
  parameter int MAX_DIM = lrc_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 write_enable,
  input  logic [lrc_pkg::INDEX_W-1:0]          register_index,
  input  logic [lrc_pkg::DIM_W-1:0]            write_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic signed [lrc_pkg::COORD_W-1:0]   x_start,
  input  logic signed [lrc_pkg::COORD_W-1:0]   y_start,
  input  logic signed [lrc_pkg::COORD_W-1:0]   x_stop,
  input  logic signed [lrc_pkg::COORD_W-1:0]   y_stop,
  input  logic [lrc_pkg::CHAN_W-1:0]           red_in,
  input  logic [lrc_pkg::CHAN_W-1:0]           green_in,
  input  logic [lrc_pkg::CHAN_W-1:0]           blue_in,
  input  logic [lrc_pkg::CHAN_W-1:0]           alpha_in,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 pixel_write,
  output logic signed [lrc_pkg::COORD_W-1:0]   pixel_x,
  output logic signed [lrc_pkg::COORD_W-1:0]   pixel_y,
  output logic [lrc_pkg::ADDR_W-1:0]           pixel_address,
  output logic                                 last_pixel,
  output logic [lrc_pkg::CHAN_W-1:0]           red_out,
  output logic [lrc_pkg::CHAN_W-1:0]           green_out,
  output logic [lrc_pkg::CHAN_W-1:0]           blue_out,
  output logic [lrc_pkg::CHAN_W-1:0]           alpha_out
);

  // Configuration registers.
  logic [lrc_pkg::DIM_W-1:0] target_width;
  logic [lrc_pkg::DIM_W-1:0] target_height;
  logic                      mask_mode;

  // Step register between the stepper and the output stage.
  logic            pix_valid;
  logic            pix_taken;
  lrc_pkg::pixel_t pix;
  logic            in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_width  <= lrc_pkg::TARGET_DIM_RESET;
      target_height <= lrc_pkg::TARGET_DIM_RESET;
      mask_mode     <= 1'b0;
    end else if (write_enable) begin
      unique case (register_index)
        lrc_pkg::REG_TARGET_WIDTH:  target_width  <= write_data;
        lrc_pkg::REG_TARGET_HEIGHT: target_height <= write_data;
        lrc_pkg::REG_MASK_MODE:     mask_mode     <= write_data[0];
        default: ;  // Writes to unused indexes are ignored.
      endcase
    end
  end

  // The step register can take a new item when it is empty or when its
  // pixel moves into the output register in the same cycle.
  assign in_stall  = pix_valid && !pix_taken;
  assign in_accept = in_valid && !in_stall;

  lrc_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .command   (command),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_stop    (x_stop),
    .y_stop    (y_stop),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .pix_taken (pix_taken),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  lrc_pixel_out #(
    .MAX_DIM (MAX_DIM)
  ) u_pixel_out (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix           (pix),
    .target_width  (target_width),
    .target_height (target_height),
    .mask_mode     (mask_mode),
    .pix_taken     (pix_taken),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .pixel_write   (pixel_write),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .last_pixel    (last_pixel),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .alpha_out     (alpha_out)
  );

endmodule

>>> design/lrc_checker.sv
`timescale 1ns / 1ps
`include "line_rasterizer_clipped_defines.svh"

// Port-level checks on the line rasterizer.
module lrc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 pixel_write,
  input logic signed [lrc_pkg::COORD_W-1:0]   pixel_x,
  input logic signed [lrc_pkg::COORD_W-1:0]   pixel_y,
  input logic [lrc_pkg::ADDR_W-1:0]           pixel_address,
  input logic                                 last_pixel
);

  localparam int CW = lrc_pkg::COORD_W;

  `LRC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_address) && $stable(pixel_write) && $stable(last_pixel), "stalled output pixel changed")
  `LRC_ASSERT_NOW(a_clip_addr_zero, clk, rst, out_valid && !pixel_write, pixel_address == '0, "clipped pixel carries a nonzero address")
  `LRC_ASSERT_NOW(a_write_nonneg, clk, rst, out_valid && pixel_write, !pixel_x[CW-1] && !pixel_y[CW-1], "pixel with negative coordinate written")
  `LRC_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind line_rasterizer_clipped lrc_checker u_lrc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .pixel_write   (pixel_write),
  .pixel_x       (pixel_x),
  .pixel_y       (pixel_y),
  .pixel_address (pixel_address),
  .last_pixel    (last_pixel)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the clipped Bresenham line rasterizer.
//
// A directed sequence exercises the corner cases first: a single-pixel line,
// the tie rule of both the X-major and the Y-major case, a line given from its
// far endpoint, a line across the full coordinate range that is dropped
// part-way by a new start, a line that crosses the target border and a tick
// that arrives after the line has ended. Random lines follow under several
// target sizes and mask settings, including a zero-sized and an oversized
// target. The registers change only between phases, once the block has gone
// quiet.
//
// The bench keeps its own model of the stepper. Every input transfer is fed
// to it at the edge where it is accepted, and every tick on an active line
// queues one expected pixel. The output monitor compares each pixel transfer,
// field by field, with the oldest expected pixel.
module tb_top;
  import lrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;

  // One input transfer: a start with its endpoints and colour, or a tick.
  typedef struct {
    logic                      cmd;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    colour_t                   ink;
  } line_cmd_t;

  // One pixel as the output channel must show it.
  typedef struct {
    logic                      write;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ADDR_W-1:0]         addr;
    logic                      last;
    colour_t                   ink;
  } pixel_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      write_enable   = 1'b0;
  logic [INDEX_W-1:0]        register_index = '0;
  logic [DIM_W-1:0]          write_data     = '0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      command  = CMD_TICK;
  logic signed [COORD_W-1:0] x_start  = '0;
  logic signed [COORD_W-1:0] y_start  = '0;
  logic signed [COORD_W-1:0] x_stop   = '0;
  logic signed [COORD_W-1:0] y_stop   = '0;
  logic [CHAN_W-1:0]         red_in   = '0;
  logic [CHAN_W-1:0]         green_in = '0;
  logic [CHAN_W-1:0]         blue_in  = '0;
  logic [CHAN_W-1:0]         alpha_in = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      pixel_write;
  logic signed [COORD_W-1:0] pixel_x;
  logic signed [COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]         pixel_address;
  logic                      last_pixel;
  logic [CHAN_W-1:0]         red_out;
  logic [CHAN_W-1:0]         green_out;
  logic [CHAN_W-1:0]         blue_out;
  logic [CHAN_W-1:0]         alpha_out;

  line_rasterizer_clipped dut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .x_start        (x_start),
    .y_start        (y_start),
    .x_stop         (x_stop),
    .y_stop         (y_stop),
    .red_in         (red_in),
    .green_in       (green_in),
    .blue_in        (blue_in),
    .alpha_in       (alpha_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_write    (pixel_write),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_address  (pixel_address),
    .last_pixel     (last_pixel),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out),
    .alpha_out      (alpha_out)
  );

  always #5 clk = ~clk;

  // Commands waiting to be driven, and pixels waiting to be seen.
  line_cmd_t     line_cmd_q[$];
  pixel_expect_t pixel_expect_q[$];

  line_cmd_t     in_flight;
  pixel_expect_t want;
  bit            in_taken   = 1'b0;
  bit            out_taken  = 1'b0;
  bit            in_calm    = 1'b0;
  bit            out_calm   = 1'b0;
  int            item_wait  = 0;
  int            out_hold   = 0;
  int            quiet_cycles = 0;
  int            fail_count = 0;

  // Register mirror, kept in step with every write on the configuration port.
  logic [DIM_W-1:0] cfg_width  = TARGET_DIM_RESET;
  logic [DIM_W-1:0] cfg_height = TARGET_DIM_RESET;
  logic             cfg_mask   = 1'b0;

  // Stepper state of the bench's own line model.
  int      pos_x = 0;
  int      pos_y = 0;
  int      major_end = 0;
  int      err = 0;
  int      span_x = 0;
  int      span_y = 0;
  bit      along_x = 1'b0;
  bit      minor_inc = 1'b0;
  bit      drawing = 1'b0;
  bit      first_px = 1'b0;
  colour_t ink = '0;

  // Target sizes and mask settings of the random phases; -1 picks at random.
  int phase_w[PHASES] = '{1024, 1, 2047, 0, 1024, 1, -1, -1};
  int phase_h[PHASES] = '{1024, 1, 2047, 300, 1, 1024, -1, -1};
  int phase_m[PHASES] = '{1, 0, 1, 0, 0, 1, -1, -1};

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(int v);
    return (v < -4096) ? -4096 : ((v > 4095) ? 4095 : v);
  endfunction

  // Each side draws a random wait for each item, but now and then switches into
  // a calm stretch where it does not wait at all.
  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(24) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(10));
  endfunction

  // Advance the line model by one accepted input transfer. A start loads the
  // line; a tick on an active line yields one pixel, the first tick giving the
  // start pixel itself. A tick with no line active yields nothing.
  task automatic bresenham_step(input line_cmd_t c);
    int            dx;
    int            dy;
    int            w;
    int            h;
    bit            fwd;
    bit            on_target;
    pixel_expect_t px;
    if (c.cmd == CMD_START) begin
      dx = int'(c.x_b) - int'(c.x_a);
      dy = int'(c.y_b) - int'(c.y_a);
      span_x = (dx < 0) ? -dx : dx;
      span_y = (dy < 0) ? -dy : dy;
      minor_inc = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
      along_x = span_y <= span_x;
      // The line is always walked upward along its major axis.
      if (along_x) begin
        fwd = dx >= 0;
        err = 2 * span_y - span_x;
        major_end = fwd ? int'(c.x_b) : int'(c.x_a);
      end else begin
        fwd = dy >= 0;
        err = 2 * span_x - span_y;
        major_end = fwd ? int'(c.y_b) : int'(c.y_a);
      end
      pos_x = fwd ? int'(c.x_a) : int'(c.x_b);
      pos_y = fwd ? int'(c.y_a) : int'(c.y_b);
      ink = c.ink;
      drawing = 1'b1;
      first_px = 1'b1;
    end else if (drawing) begin
      if (first_px) begin
        first_px = 1'b0;
      end else if (along_x) begin
        // X-major: the minor axis holds only while the error is negative.
        pos_x++;
        if (err < 0) begin
          err += 2 * span_y;
        end else begin
          pos_y += minor_inc ? 1 : -1;
          err += 2 * (span_y - span_x);
        end
      end else begin
        // Y-major: the minor axis also holds on a zero error.
        pos_y++;
        if (err <= 0) begin
          err += 2 * span_x;
        end else begin
          pos_x += minor_inc ? 1 : -1;
          err += 2 * (span_x - span_y);
        end
      end
      px.last = (along_x ? pos_x : pos_y) >= major_end;
      if (px.last) drawing = 1'b0;
      // Target sizes above the maximum saturate; a zero size clips everything.
      w = (cfg_width > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(cfg_width);
      h = (cfg_height > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(cfg_height);
      on_target = pos_x >= 0 && pos_y >= 0 && pos_x < w && pos_y < h;
      px.write = on_target && (!cfg_mask || ink.alpha == ALPHA_OPAQUE);
      px.addr = px.write ? ADDR_W'(pos_x + pos_y * w) : '0;
      px.x = COORD_W'(pos_x);
      px.y = COORD_W'(pos_y);
      px.ink = ink;
      pixel_expect_q.push_back(px);
    end
  endtask

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, actual %0d", name, $signed(expected), $signed(actual));
      fail_count++;
    end
  endtask

  task automatic push_start(int xa, int ya, int xb, int yb, colour_t c);
    line_cmd_t it;
    it.cmd = CMD_START;
    it.x_a = COORD_W'(xa);
    it.y_a = COORD_W'(ya);
    it.x_b = COORD_W'(xb);
    it.y_b = COORD_W'(yb);
    it.ink = c;
    line_cmd_q.push_back(it);
  endtask

  task automatic push_ticks(int n);
    line_cmd_t it;
    // Endpoint and colour fields are don't-care on a tick; fill them with noise.
    for (int i = 0; i < n; i++) begin
      it.cmd = CMD_TICK;
      it.x_a = COORD_W'($urandom);
      it.y_a = COORD_W'($urandom);
      it.x_b = COORD_W'($urandom);
      it.y_b = COORD_W'($urandom);
      it.ink = colour_t'($urandom);
      line_cmd_q.push_back(it);
    end
  endtask

  // Random lines for the current target. Most are short lines near the
  // target, walked to their end; some are dropped early by the next start,
  // some get spare ticks after their last pixel, and a few span the whole
  // coordinate range.
  task automatic queue_random_lines(int budget);
    int      reach_w;
    int      reach_h;
    int      x0;
    int      y0;
    int      x1;
    int      y1;
    int      ax;
    int      ay;
    int      len;
    int      ticks;
    int      count;
    colour_t c;
    count = 0;
    reach_w = (cfg_width > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(cfg_width);
    reach_h = (cfg_height > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(cfg_height);
    while (count < budget) begin
      c = colour_t'($urandom);
      if ($urandom_range(1) == 0) c.alpha = ALPHA_OPAQUE;
      if ($urandom_range(9) == 0) begin
        x0 = rand_in(-4096, 4095);
        y0 = rand_in(-4096, 4095);
        if ($urandom_range(1) == 0) begin
          x1 = rand_in(-4096, 4095);
          y1 = rand_in(-4096, 4095);
        end else begin
          x1 = clamp_coord(x0 + rand_in(-12, 12));
          y1 = clamp_coord(y0 + rand_in(-12, 12));
        end
      end else begin
        x0 = rand_in(-8, reach_w + 8);
        y0 = rand_in(-8, reach_h + 8);
        x1 = x0 + rand_in(-12, 12);
        y1 = y0 + rand_in(-12, 12);
      end
      ax = (x1 > x0) ? x1 - x0 : x0 - x1;
      ay = (y1 > y0) ? y1 - y0 : y0 - y1;
      len = ((ax > ay) ? ax : ay) + 1;
      if (len > 40) begin
        ticks = rand_in(0, 15);
      end else begin
        case ($urandom_range(9))
          0, 1: ticks = rand_in(0, len - 1);
          2: ticks = len + rand_in(1, 3);
          default: ticks = len;
        endcase
      end
      push_start(x0, y0, x1, y1, c);
      push_ticks(ticks);
      count += 1 + ((ticks < len) ? ticks : len);
    end
  endtask

  // Wait until every command has gone in and every pixel has come out, then
  // give the pipeline time to finish a trailing start or idle tick.
  task automatic settle();
    do @(posedge clk);
    while (!(line_cmd_q.size() == 0 && !in_valid && pixel_expect_q.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= val;
    case (idx)
      REG_TARGET_WIDTH:  cfg_width  = val;
      REG_TARGET_HEIGHT: cfg_height = val;
      default:           cfg_mask   = val[0];
    endcase
  endtask

  task automatic set_target(int w, int h, int m);
    write_reg(REG_TARGET_WIDTH, DIM_W'(w));
    write_reg(REG_TARGET_HEIGHT, DIM_W'(h));
    write_reg(REG_MASK_MODE, DIM_W'(m));
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // Input side: note each transfer and run it through the line model at the
  // same edge, so the model sees commands exactly in the order accepted.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      in_taken = 1'b1;
      bresenham_step(in_flight);
    end
  end

  // Input driver. A presented command holds until it is transferred; then the
  // next one comes after its own random wait.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (item_wait > 0) begin
        item_wait--;
        in_valid <= 1'b0;
      end else if (line_cmd_q.size() > 0) begin
        in_flight = line_cmd_q.pop_front();
        command  <= in_flight.cmd;
        x_start  <= in_flight.x_a;
        y_start  <= in_flight.y_a;
        x_stop   <= in_flight.x_b;
        y_stop   <= in_flight.y_b;
        red_in   <= in_flight.ink.red;
        green_in <= in_flight.ink.green;
        blue_in  <= in_flight.ink.blue;
        alpha_in <= in_flight.ink.alpha;
        in_valid <= 1'b1;
        item_wait = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: every pixel transfer must match the oldest expected pixel.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_taken = 1'b1;
      if (pixel_expect_q.size() == 0) begin
        $error("pixel at x=%0d y=%0d with none expected", pixel_x, pixel_y);
        fail_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        check_field("pixel_write", want.write, pixel_write);
        check_field("pixel_x", want.x, pixel_x);
        check_field("pixel_y", want.y, pixel_y);
        check_field("pixel_address", want.addr, pixel_address);
        check_field("last_pixel", want.last, last_pixel);
        check_field("red_out", want.ink.red, red_out);
        check_field("green_out", want.ink.green, green_out);
        check_field("blue_out", want.ink.blue, blue_out);
        check_field("alpha_out", want.ink.alpha, alpha_out);
      end
    end
  end

  // Output stall. After each pixel transfer a new hold count is drawn; it runs
  // down only while a pixel is offered, so each pixel waits that long. A
  // nonzero count also stalls an idle channel, which meets the next pixel.
  always @(negedge clk) begin
    if (out_taken) begin
      out_hold = pick_gap(out_calm);
      out_taken = 1'b0;
    end
    out_stall <= out_hold > 0;
    if (out_valid && out_hold > 0) out_hold--;
  end

  // Watchdog: a long run of cycles with no transfer on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed lines on the reset target of 256 x 256, mask off.
    // A line whose endpoints coincide is one pixel, flagged last.
    push_start(7, 7, 7, 7, colour_t'(32'h00000000));
    push_ticks(1);
    // X-major with a zero starting error: the minor axis steps on the tie.
    push_start(0, 0, 4, 2, colour_t'(32'hFFFFFFFF));
    push_ticks(5);
    // Y-major given from its upper endpoint; the zero error holds x on the tie.
    push_start(2, 4, 0, 0, colour_t'(32'hFF123456));
    push_ticks(5);
    // Full-range diagonal, off target, dropped after two pixels by a new start.
    push_start(-4096, 4095, 4095, -4096, colour_t'(32'h00FF00FF));
    push_ticks(2);
    // Diagonal walked backward across the right and bottom borders, followed
    // by one tick after the line has ended.
    push_start(258, 250, 250, 258, colour_t'(32'h80A0C0E0));
    push_ticks(10);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_target((phase_w[p] < 0) ? rand_in(1, 1024) : phase_w[p],
                 (phase_h[p] < 0) ? rand_in(1, 1024) : phase_h[p],
                 (phase_m[p] < 0) ? rand_in(0, 1) : phase_m[p]);
      queue_random_lines(48);
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pixel_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
